/* design/srr_pkg.sv */
// Package for the slot range replica router.
// Holds sizes, operation, policy and status codes, and the structs shared by the modules.
package srr_pkg;

	localparam int MAX_SETS = 64;
	localparam int ROW_W = $clog2(MAX_SETS);
	localparam int MAX_SEC = 4;
	localparam int LANES = MAX_SEC + 1;
	localparam int LANE_W = 3;
	localparam int SLOT_W = 14;
	localparam int SITE_W = 8;
	localparam int ID_W = 64;
	localparam int CNT_W = 32;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SET = 2'd1;
	localparam logic [1:0] OP_REP = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	localparam logic [1:0] POL_PRIMARY = 2'd1;
	localparam logic [1:0] POL_AFFINITY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [1:0] ST_NOPRI = 2'd3;

	typedef struct packed {
		logic [SLOT_W-1:0] start;
		logic [SLOT_W-1:0] stop;
		logic [ID_W-1:0] sid;
		logic [LANE_W-1:0] nsec;
	} row_t;

	typedef struct packed {
		logic row_we;
		logic rep_we;
		logic rep_clr;
		logic cnt_we;
		logic [ROW_W-1:0] rd_addr;
		logic [ROW_W-1:0] wr_addr;
		logic [LANE_W-1:0] lane;
		row_t row;
		logic [ID_W-1:0] rep_id;
		logic [SITE_W-1:0] rep_site;
		logic [CNT_W-1:0] cnt;
	} store_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ID_W-1:0] set_id;
		logic [ID_W-1:0] replica_id;
		logic [LANE_W-1:0] replica_pos;
	} result_t;

endpackage

/* design/srr_req_if.sv */
// Request channel of the slot range replica router.
// Depends on srr_pkg for field widths.
interface srr_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [srr_pkg::ROW_W-1:0] set_index;
	logic [srr_pkg::LANE_W-1:0] replica_index;
	logic [srr_pkg::SLOT_W-1:0] slot;
	logic [srr_pkg::SLOT_W-1:0] last_slot;
	logic [srr_pkg::ID_W-1:0] entry_id;
	logic [srr_pkg::LANE_W-1:0] secondary_count;
	logic [srr_pkg::SITE_W-1:0] site_code;
	logic [1:0] pick_policy;

	modport source (output valid, operation, set_index, replica_index, slot, last_slot,
		entry_id, secondary_count, site_code, pick_policy, input ready);
	modport sink (input valid, operation, set_index, replica_index, slot, last_slot,
		entry_id, secondary_count, site_code, pick_policy, output ready);
endinterface

/* design/srr_rsp_if.sv */
// Response channel of the slot range replica router.
// Depends on srr_pkg for field widths.
interface srr_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [srr_pkg::ID_W-1:0] set_id;
	logic [srr_pkg::ID_W-1:0] replica_id;
	logic [srr_pkg::LANE_W-1:0] replica_pos;

	modport source (output valid, status, set_id, replica_id, replica_pos, input ready);
	modport sink (input valid, status, set_id, replica_id, replica_pos, output ready);
endinterface

/* design/srr_store.sv */
// Table storage: row memory, per-lane replica memory and round-robin counters.
// All reads share one row address and return registered data. Depends on srr_pkg.
module srr_store (
	input  logic clk,
	input  srr_pkg::store_req_t req,
	output srr_pkg::row_t row_rd,
	output logic [srr_pkg::LANES-1:0][srr_pkg::ID_W-1:0] ids_rd,
	output logic [srr_pkg::LANES-1:0][srr_pkg::SITE_W-1:0] sites_rd,
	output logic [srr_pkg::CNT_W-1:0] cnt_rd
);
	srr_pkg::row_t row_mem [srr_pkg::MAX_SETS];
	logic [srr_pkg::LANES-1:0][srr_pkg::ID_W+srr_pkg::SITE_W-1:0] rep_mem [srr_pkg::MAX_SETS];
	logic [srr_pkg::CNT_W-1:0] cnt_mem [srr_pkg::MAX_SETS];
	logic [srr_pkg::LANES-1:0][srr_pkg::ID_W+srr_pkg::SITE_W-1:0] rep_rd;

	// Writes, one lane of the replica row at a time; a clear zeroes the ids of a whole
	// row and keeps its sites.
	always_ff @(posedge clk) begin
		if (req.row_we) begin
			row_mem[req.wr_addr] <= req.row;
		end
		if (req.rep_we) begin
			rep_mem[req.wr_addr][req.lane] <= {req.rep_id, req.rep_site};
		end else if (req.rep_clr) begin
			for (int p = 0; p < srr_pkg::LANES; p++) begin
				rep_mem[req.wr_addr][p][srr_pkg::ID_W+srr_pkg::SITE_W-1:srr_pkg::SITE_W] <= '0;
			end
		end
		if (req.cnt_we) begin
			cnt_mem[req.wr_addr] <= req.cnt;
		end
	end

	// Registered reads.
	always_ff @(posedge clk) begin
		row_rd <= row_mem[req.rd_addr];
		rep_rd <= rep_mem[req.rd_addr];
		cnt_rd <= cnt_mem[req.rd_addr];
	end

	// Split each lane into id and site.
	always_comb begin
		for (int p = 0; p < srr_pkg::LANES; p++) begin
			ids_rd[p] = rep_rd[p][srr_pkg::ID_W+srr_pkg::SITE_W-1:srr_pkg::SITE_W];
			sites_rd[p] = rep_rd[p][srr_pkg::SITE_W-1:0];
		end
	end
endmodule

/* design/slot_range_replica_router_core.sv */
// Slot range replica router: one request beat in, one response beat out.
// A write goes straight to the final step; a clear first runs a pass zeroing the replica ids of
// every row. A lookup scans all rows, reads the selected row and evaluates it, adding the modulo
// and pick steps when a modulo pick is needed; the next beat is taken once the final step is left.
// One request at a time; a finished response waits in the output register.
// Asynchronous active-low reset clears the row valid bits, the controller state and the output
// valid, then runs the id clearing pass over every row with ready low.
module slot_range_replica_router_core (
	input logic clk,
	input logic arst_n,
	srr_req_if.sink req,
	srr_rsp_if.source rsp
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_SCAN = 8'b00000010,
		S_ROW  = 8'b00000100,
		S_EVAL = 8'b00001000,
		S_MOD  = 8'b00010000,
		S_PICK = 8'b00100000,
		S_DONE = 8'b01000000,
		S_CLR  = 8'b10000000
	} state_t;

	state_t state_q;
	logic [srr_pkg::MAX_SETS-1:0] row_valid_q;
	logic clr_op_q;
	srr_pkg::store_req_t sreq;
	srr_pkg::row_t row_rd;
	logic [srr_pkg::LANES-1:0][srr_pkg::ID_W-1:0] ids_rd;
	logic [srr_pkg::LANES-1:0][srr_pkg::SITE_W-1:0] sites_rd;
	logic [srr_pkg::CNT_W-1:0] cnt_rd;

	logic [srr_pkg::SLOT_W-1:0] slot_q;
	logic [srr_pkg::SITE_W-1:0] site_q;
	logic [1:0] policy_q;
	logic [srr_pkg::ROW_W:0] scan_q;
	logic cmp_v_s1;
	logic [srr_pkg::ROW_W-1:0] cmp_idx_s1;
	logic found_q;
	logic [srr_pkg::ROW_W-1:0] best_q;
	logic [srr_pkg::SLOT_W-1:0] best_start_q;
	logic [1:0] vcnt_q;
	logic [srr_pkg::ROW_W-1:0] lone_q;
	logic [srr_pkg::ROW_W-1:0] sel_q;
	logic [srr_pkg::LANES-1:0] mvec_q;
	logic [srr_pkg::LANE_W-1:0] div_q;
	logic aff_q;
	logic [9:0] sum_q;
	logic [1:0] cnt_lo_q;
	logic [8:0] q3_q;
	logic [7:0] q5_q;
	srr_pkg::result_t res_q;
	logic rsp_v_q;
	srr_pkg::result_t rsp_q;

	logic accept;
	logic [srr_pkg::LANES-1:0] mvec;
	logic [srr_pkg::LANE_W-1:0] nc;
	logic [srr_pkg::CNT_W-1:0] cnt_new;
	logic [9:0] sum;
	logic [srr_pkg::ROW_W-1:0] row_sel;
	logic [2:0] resid;
	logic [srr_pkg::LANE_W-1:0] pos_aff;
	logic [srr_pkg::LANE_W-1:0] rank;
	logic [srr_pkg::LANE_W-1:0] pos;
	logic [19:0] prod3;
	logic [17:0] prod5;
	logic [1:0] r3;
	logic [2:0] r5;

	srr_store u_store (
		.clk(clk), .req(sreq), .row_rd(row_rd), .ids_rd(ids_rd), .sites_rd(sites_rd),
		.cnt_rd(cnt_rd)
	);

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign row_sel = found_q ? best_q : lone_q;

	// Site matches among the primary and the row's secondaries.
	always_comb begin
		nc = '0;
		for (int p = 0; p < srr_pkg::LANES; p++) begin
			mvec[p] = (srr_pkg::LANE_W'(p) <= row_rd.nsec) && (sites_rd[p] == site_q);
			nc = nc + srr_pkg::LANE_W'(mvec[p]);
		end
	end

	// Counter advance and byte fold; 256 is 1 modulo both 3 and 5.
	assign cnt_new = cnt_rd + 1'b1;
	assign sum = 10'(cnt_new[7:0]) + 10'(cnt_new[15:8]) + 10'(cnt_new[23:16])
		+ 10'(cnt_new[31:24]);

	// Reciprocal multiplies for division by three and by five.
	assign prod3 = 20'(sum_q) * 20'd683;
	assign prod5 = 18'(sum_q) * 18'd205;

	// Remainder by the divisor, then the picked position.
	always_comb begin
		r3 = 2'(sum_q - 10'(q3_q) * 10'd3);
		r5 = 3'(sum_q - 10'(q5_q) * 10'd5);
		case (div_q)
			3'd2: resid = {2'b00, cnt_lo_q[0]};
			3'd3: resid = {1'b0, r3};
			3'd4: resid = {1'b0, cnt_lo_q};
			3'd5: resid = r5;
			default: resid = '0;
		endcase
		rank = '0;
		pos_aff = '0;
		for (int p = 0; p < srr_pkg::LANES; p++) begin
			if (mvec_q[p]) begin
				if (rank == resid) begin
					pos_aff = srr_pkg::LANE_W'(p);
				end
				rank = rank + 1'b1;
			end
		end
		pos = aff_q ? pos_aff : resid + 1'b1;
	end

	// Store requests.
	always_comb begin
		sreq = '0;
		sreq.wr_addr = req.set_index;
		sreq.lane = req.replica_index;
		sreq.row.start = req.slot;
		sreq.row.stop = req.last_slot;
		sreq.row.sid = req.entry_id;
		sreq.row.nsec = (req.secondary_count > srr_pkg::LANE_W'(srr_pkg::MAX_SEC))
			? srr_pkg::LANE_W'(srr_pkg::MAX_SEC) : req.secondary_count;
		sreq.rep_id = req.entry_id;
		sreq.rep_site = req.site_code;
		sreq.cnt = '0;
		sreq.rd_addr = scan_q[srr_pkg::ROW_W-1:0];
		if (accept && req.operation == srr_pkg::OP_SET) begin
			sreq.row_we = 1'b1;
			sreq.cnt_we = 1'b1;
		end
		if (accept && req.operation == srr_pkg::OP_REP
			&& req.replica_index <= srr_pkg::LANE_W'(srr_pkg::MAX_SEC)) begin
			sreq.rep_we = 1'b1;
		end
		if (state_q == S_CLR) begin
			sreq.wr_addr = scan_q[srr_pkg::ROW_W-1:0];
			sreq.rep_clr = 1'b1;
		end
		if (state_q == S_ROW) begin
			sreq.rd_addr = row_sel;
		end
		if (state_q == S_EVAL || state_q == S_MOD || state_q == S_PICK) begin
			sreq.rd_addr = sel_q;
		end
		if (state_q == S_EVAL) begin
			sreq.wr_addr = sel_q;
			sreq.cnt = cnt_new;
			sreq.cnt_we = ids_rd[0] != '0 && policy_q != srr_pkg::POL_PRIMARY
				&& row_rd.nsec != '0 && vcnt_q != 2'd0
				&& !(vcnt_q == 2'd2 && (!found_q || slot_q > row_rd.stop));
		end
	end

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			row_valid_q <= '0;
			clr_op_q <= 1'b0;
			rsp_v_q <= 1'b0;
			scan_q <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			// Output register: load from the final step, or empty on a taken beat.
			if (state_q == S_DONE && (!rsp_v_q || rsp.ready)) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						slot_q <= req.slot;
						site_q <= req.site_code;
						policy_q <= req.pick_policy;
						scan_q <= '0;
						found_q <= 1'b0;
						vcnt_q <= 2'd0;
						clr_op_q <= req.operation == srr_pkg::OP_CLEAR;
						case (req.operation)
							srr_pkg::OP_CLEAR: begin
								row_valid_q <= '0;
								state_q <= S_CLR;
							end
							srr_pkg::OP_SET: begin
								row_valid_q[req.set_index] <= 1'b1;
								state_q <= S_DONE;
							end
							srr_pkg::OP_REP: begin
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_CLR: begin
					// Zero the replica ids of one row per cycle.
					scan_q <= scan_q + 1'b1;
					if (scan_q[srr_pkg::ROW_W-1:0] == srr_pkg::ROW_W'(srr_pkg::MAX_SETS - 1)) begin
						state_q <= clr_op_q ? S_DONE : S_IDLE;
					end
				end
				S_SCAN: begin
					// Issue one row read per cycle, compare the row read last cycle.
					cmp_v_s1 <= scan_q != (srr_pkg::ROW_W+1)'(srr_pkg::MAX_SETS);
					cmp_idx_s1 <= scan_q[srr_pkg::ROW_W-1:0];
					if (scan_q != (srr_pkg::ROW_W+1)'(srr_pkg::MAX_SETS)) begin
						scan_q <= scan_q + 1'b1;
					end
					if (cmp_v_s1 && row_valid_q[cmp_idx_s1]) begin
						if (vcnt_q != 2'd2) begin
							vcnt_q <= vcnt_q + 1'b1;
						end
						lone_q <= cmp_idx_s1;
						if (row_rd.start <= slot_q
							&& (!found_q || row_rd.start > best_start_q)) begin
							found_q <= 1'b1;
							best_q <= cmp_idx_s1;
							best_start_q <= row_rd.start;
						end
					end
					if (cmp_v_s1 && cmp_idx_s1 == srr_pkg::ROW_W'(srr_pkg::MAX_SETS - 1)) begin
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					sel_q <= row_sel;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (vcnt_q == 2'd0) begin
						res_q.status <= srr_pkg::ST_EMPTY;
						state_q <= S_DONE;
					end else if (vcnt_q == 2'd2 && (!found_q || slot_q > row_rd.stop)) begin
						res_q.status <= srr_pkg::ST_MISS;
						state_q <= S_DONE;
					end else if (ids_rd[0] == '0) begin
						res_q.status <= srr_pkg::ST_NOPRI;
						res_q.set_id <= row_rd.sid;
						state_q <= S_DONE;
					end else if (policy_q == srr_pkg::POL_PRIMARY || row_rd.nsec == '0) begin
						res_q.set_id <= row_rd.sid;
						res_q.replica_id <= ids_rd[0];
						state_q <= S_DONE;
					end else begin
						res_q.set_id <= row_rd.sid;
						aff_q <= policy_q == srr_pkg::POL_AFFINITY && nc != '0;
						div_q <= (policy_q == srr_pkg::POL_AFFINITY && nc != '0)
							? nc : row_rd.nsec;
						mvec_q <= mvec;
						sum_q <= sum;
						cnt_lo_q <= cnt_new[1:0];
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					q3_q <= prod3[19:11];
					q5_q <= prod5[17:10];
					state_q <= S_PICK;
				end
				S_PICK: begin
					res_q.replica_pos <= pos;
					res_q.replica_id <= ids_rd[pos];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_v_q || rsp.ready) begin
						rsp_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_v_q;
	assign rsp.status = rsp_q.status;
	assign rsp.set_id = rsp_q.set_id;
	assign rsp.replica_id = rsp_q.replica_id;
	assign rsp.replica_pos = rsp_q.replica_pos;

`ifndef SYNTH
	// A counter write outside a set write comes only from the evaluate step.
	assert property (@(posedge clk) disable iff (!arst_n)
		sreq.cnt_we |-> (state_q == S_EVAL || accept))
		else $error("counter write outside evaluate or set write");
	// The picked position never lies beyond the row's secondaries.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PICK |-> pos <= row_rd.nsec)
		else $error("picked position beyond secondary count");
	// Leaving the final step always presents a response.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!rsp_v_q || rsp.ready)) |=> rsp_v_q)
		else $error("response lost");
	// A successful modulo pick only happens on a valid row.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PICK |-> row_valid_q[sel_q])
		else $error("pick on an invalid row");
`endif
endmodule

/* sim/srr_route_checker.sv */
// Checker for the slot range replica router: predicts every response from the request beats.
// Depends on srr_pkg and on the srr_req_if and srr_rsp_if channel interfaces.
module srr_route_checker (
	input logic clk,
	input logic arst_n,
	srr_req_if req,
	srr_rsp_if rsp,
	output int fail_count,
	output int pending
);
	import srr_pkg::*;

	// Shadow copy of the routing table.
	logic row_on [MAX_SETS];
	logic [SLOT_W-1:0] row_first [MAX_SETS];
	logic [SLOT_W-1:0] row_last [MAX_SETS];
	logic [ID_W-1:0] row_sid [MAX_SETS];
	logic [LANE_W-1:0] row_nsec [MAX_SETS];
	logic [ID_W-1:0] lane_id [MAX_SETS*LANES];
	logic [SITE_W-1:0] lane_site [MAX_SETS*LANES];
	logic [CNT_W-1:0] row_turn [MAX_SETS];

	result_t routes_due [$];

	task automatic report_mismatch(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Resolves one lookup against the shadow table and, for a modulo pick, advances the row's turn counter.
	function automatic result_t route_lookup(logic [SLOT_W-1:0] slot, logic [SITE_W-1:0] site,
			logic [1:0] policy);
		result_t res;
		int n_valid, best, lone, base, nsec, nc, pos;
		logic found;
		logic [CNT_W-1:0] turn;
		int cands [LANES];
		res = '0;
		n_valid = 0;
		best = 0;
		lone = 0;
		nc = 0;
		found = 1'b0;
		for (int i = 0; i < MAX_SETS; i++) begin
			if (row_on[i]) begin
				n_valid++;
				lone = i;
				if (row_first[i] <= slot && (!found || row_first[i] > row_first[best])) begin
					best = i;
					found = 1'b1;
				end
			end
		end
		if (n_valid == 0) begin
			res.status = ST_EMPTY;
			return res;
		end
		if (!found) begin
			if (n_valid != 1) begin
				res.status = ST_MISS;
				return res;
			end
			best = lone;
		end else if (slot > row_last[best] && n_valid != 1) begin
			res.status = ST_MISS;
			return res;
		end
		base = best * LANES;
		nsec = row_nsec[best];
		res.set_id = row_sid[best];
		if (lane_id[base] == '0) begin
			res.status = ST_NOPRI;
			return res;
		end
		res.status = ST_OK;
		if (policy == POL_PRIMARY || nsec == 0) begin
			res.replica_id = lane_id[base];
			return res;
		end
		row_turn[best] = row_turn[best] + 1'b1;
		turn = row_turn[best];
		if (policy == POL_AFFINITY) begin
			for (int p = 0; p <= nsec; p++) begin
				if (lane_site[base+p] == site) begin
					cands[nc] = p;
					nc++;
				end
			end
		end
		if (nc != 0)
			pos = cands[turn % CNT_W'(nc)];
		else
			pos = int'(turn % CNT_W'(nsec)) + 1;
		res.replica_id = lane_id[base+pos];
		res.replica_pos = LANE_W'(pos);
		return res;
	endfunction

	// Track accepted requests and compare accepted responses.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int base;
		if (!arst_n) begin
			for (int i = 0; i < MAX_SETS; i++) begin
				row_on[i] = 1'b0;
				row_turn[i] = '0;
			end
			for (int i = 0; i < MAX_SETS*LANES; i++) begin
				lane_id[i] = '0;
				lane_site[i] = '0;
			end
			routes_due.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (routes_due.size() == 0) begin
					$display("%0t: response beat with nothing outstanding", $realtime);
					fail_count++;
				end else begin
					want = routes_due.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", ID_W'(rsp.status), ID_W'(want.status));
					if (rsp.set_id !== want.set_id)
						report_mismatch("set_id", rsp.set_id, want.set_id);
					if (rsp.replica_id !== want.replica_id)
						report_mismatch("replica_id", rsp.replica_id, want.replica_id);
					if (rsp.replica_pos !== want.replica_pos)
						report_mismatch("replica_pos", ID_W'(rsp.replica_pos),
							ID_W'(want.replica_pos));
				end
			end
			if (req.valid && req.ready) begin
				want = '0;
				base = int'(req.set_index) * LANES;
				case (req.operation)
					OP_CLEAR: begin
						for (int i = 0; i < MAX_SETS; i++) begin
							row_on[i] = 1'b0;
							row_turn[i] = '0;
						end
						for (int i = 0; i < MAX_SETS*LANES; i++)
							lane_id[i] = '0;
					end
					OP_SET: begin
						row_on[req.set_index] = 1'b1;
						row_first[req.set_index] = req.slot;
						row_last[req.set_index] = req.last_slot;
						row_sid[req.set_index] = req.entry_id;
						row_nsec[req.set_index] = (req.secondary_count > MAX_SEC) ?
							LANE_W'(MAX_SEC) : req.secondary_count;
						row_turn[req.set_index] = '0;
					end
					OP_REP: begin
						if (req.replica_index <= MAX_SEC) begin
							lane_id[base+req.replica_index] = req.entry_id;
							lane_site[base+req.replica_index] = req.site_code;
						end
					end
					default: want = route_lookup(req.slot, req.site_code, req.pick_policy);
				endcase
				routes_due = {routes_due, want};
			end
			pending <= routes_due.size();
		end
	end
endmodule

/* sim/tb_slot_range_replica_router_core.sv */
// Top of the slot range replica router testbench: clock, reset, request stimulus, response
// stalls and the verdict. Depends on srr_pkg, the channel interfaces and srr_route_checker.
module tb_slot_range_replica_router_core;
	import srr_pkg::*;

	typedef struct {
		logic [1:0] op;
		logic [ROW_W-1:0] row;
		logic [LANE_W-1:0] lane;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] stop;
		logic [ID_W-1:0] id;
		logic [LANE_W-1:0] nsec;
		logic [SITE_W-1:0] site;
		logic [1:0] policy;
	} route_req_t;

	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1900;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int idle_cycles = 0;
	int burst_left;
	int sent;

	// Stimulus-side bookkeeping so that affinity lookups only read written sites.
	logic row_live [MAX_SETS];
	logic site_set [MAX_SETS][LANES];
	logic [SLOT_W-1:0] live_first [MAX_SETS];

	srr_req_if req ();
	srr_rsp_if rsp ();

	slot_range_replica_router_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	srr_route_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Clock with a 12-unit period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// The receiver alternates between free flow, random stalls and long stalls.
	always @(negedge clk) begin
		int mode;
		int mode_left;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			mode = 0;
			mode_left = 0;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 200);
			end
			mode_left--;
			case (mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= 1'($urandom_range(0, 1));
				default: rsp.ready <= ($urandom_range(0, 29) == 0);
			endcase
		end
	end

	// A run with no beat on either channel for too long is a hang.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("tb_slot_range_replica_router_core: done, errors");
			$finish;
		end
	end

	function automatic logic affinity_safe();
		for (int r = 0; r < MAX_SETS; r++)
			for (int p = 0; p < LANES; p++)
				if (row_live[r] && !site_set[r][p])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [SITE_W-1:0] pick_site();
		if ($urandom_range(0, 3) == 0)
			return SITE_W'($urandom);
		return SITE_W'($urandom_range(0, 2));
	endfunction

	// Sends one beat, in bursts with random gaps between them.
	task automatic send(route_req_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 20);
			repeat (gap) begin
				req.valid <= 1'b0;
				@(negedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.operation <= it.op;
		req.set_index <= it.row;
		req.replica_index <= it.lane;
		req.slot <= it.slot;
		req.last_slot <= it.stop;
		req.entry_id <= it.id;
		req.secondary_count <= it.nsec;
		req.site_code <= it.site;
		req.pick_policy <= it.policy;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
		case (it.op)
			OP_CLEAR:
				for (int r = 0; r < MAX_SETS; r++)
					row_live[r] = 1'b0;
			OP_SET: begin
				row_live[it.row] = 1'b1;
				live_first[it.row] = it.slot;
			end
			OP_REP: site_set[it.row][it.lane] = 1'b1;
			default: ;
		endcase
		sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic route_req_t blank(logic [1:0] op);
		route_req_t it;
		it.op = op;
		it.row = '0;
		it.lane = '0;
		it.slot = '0;
		it.stop = '0;
		it.id = '0;
		it.nsec = '0;
		it.site = '0;
		it.policy = '0;
		return it;
	endfunction

	function automatic route_req_t set_row(int row, int first, int last, logic [ID_W-1:0] id,
			int nsec);
		route_req_t it;
		it = blank(OP_SET);
		it.row = ROW_W'(row);
		it.slot = SLOT_W'(first);
		it.stop = SLOT_W'(last);
		it.id = id;
		it.nsec = LANE_W'(nsec);
		return it;
	endfunction

	function automatic route_req_t set_lane(int row, int lane, logic [ID_W-1:0] id, int site);
		route_req_t it;
		it = blank(OP_REP);
		it.row = ROW_W'(row);
		it.lane = LANE_W'(lane);
		it.id = id;
		it.site = SITE_W'(site);
		return it;
	endfunction

	function automatic route_req_t lookup(int slot, logic [1:0] policy, int site);
		route_req_t it;
		it = blank(OP_LOOKUP);
		it.slot = SLOT_W'(slot);
		it.policy = policy;
		it.site = SITE_W'(site);
		return it;
	endfunction

	// Lookup: slot near any row's recorded start or random; random policy and affinity site.
	function automatic route_req_t random_lookup();
		route_req_t it;
		int r;
		int slot;
		r = $urandom_range(0, MAX_SETS-1);
		slot = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383) :
			int'(live_first[r]) + $urandom_range(0, 300) - 20;
		if (slot < 0)
			slot = 0;
		if (slot > 16383)
			slot = 16383;
		it = lookup(slot, 2'($urandom_range(0, 2)), pick_site());
		if (it.policy == POL_AFFINITY && !affinity_safe())
			it.policy = 2'd0;
		return it;
	endfunction

	initial begin
		int row;
		int first;
		int kind;
		int cnt;
		req.valid = 1'b0;
		req.operation = OP_CLEAR;
		req.set_index = '0;
		req.replica_index = '0;
		req.slot = '0;
		req.last_slot = '0;
		req.entry_id = '0;
		req.secondary_count = '0;
		req.site_code = '0;
		req.pick_policy = '0;
		burst_left = 0;
		sent = 0;
		for (int r = 0; r < MAX_SETS; r++) begin
			row_live[r] = 1'b0;
			live_first[r] = '0;
			for (int p = 0; p < LANES; p++)
				site_set[r][p] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty table, lone set, missing primary, policies, equal starts, misses.
		send(lookup(5, 2'd0, 0));
		send(blank(OP_CLEAR));
		send(set_row(5, 100, 200, 64'h1234_5678_9abc_def0, 2));
		send(lookup(50, 2'd0, 0));
		send(set_lane(5, 0, 64'hffff_ffff_ffff_ffff, 1));
		send(set_lane(5, 1, 64'h11, 2));
		send(set_lane(5, 2, 64'h22, 1));
		send(set_lane(5, 3, 64'h33, 255));
		send(set_lane(5, 4, 64'h44, 0));
		send(lookup(16383, POL_PRIMARY, 0));
		send(lookup(150, 2'd0, 0));
		send(lookup(150, 2'd0, 0));
		send(lookup(150, POL_AFFINITY, 1));
		send(lookup(150, POL_AFFINITY, 1));
		send(lookup(150, POL_AFFINITY, 7));
		send(set_row(9, 100, 16383, '1, 4));
		send(set_row(63, 16383, 16383, 64'h1, 0));
		send(lookup(0, 2'd0, 0));
		send(lookup(300, 2'd0, 0));
		send(lookup(16383, 2'd0, 0));
		send(set_lane(63, 0, 64'h8000_0000_0000_0000, 0));
		send(lookup(16383, POL_AFFINITY, 0));
		send(set_row(0, 0, 0, '0, 0));
		send(lookup(0, POL_PRIMARY, 0));
		drain();

		// Random: mostly lookups, mixed with built sets, noise writes and rare clears.
		while (sent < RANDOM_ITEMS + 24) begin
			kind = $urandom_range(0, 99);
			if (kind < 2) begin
				send(blank(OP_CLEAR));
			end else if (kind < 22) begin
				row = $urandom_range(0, 63);
				first = $urandom_range(0, 7) == 0 ? $urandom_range(0, 16383) :
					$urandom_range(0, 40) * 400;
				cnt = $urandom_range(0, 4);
				send(set_row(row, first, first + $urandom_range(0, 800) > 16383 ? 16383 :
					first + $urandom_range(0, 800), pick_id(), cnt));
				for (int p = 0; p < LANES; p++)
					send(set_lane(row, p, p == 0 && $urandom_range(0, 15) == 0 ? '0 :
						{$urandom, $urandom}, pick_site()));
			end else if (kind < 30) begin
				send(set_lane($urandom_range(0, 63), $urandom_range(0, 4), pick_id(),
					pick_site()));
			end else if (kind < 33) begin
				send(set_row($urandom_range(0, 63), $urandom_range(0, 16383),
					$urandom_range(0, 16383), pick_id(), $urandom_range(0, 4)));
			end else begin
				repeat ($urandom_range(1, 6))
					send(random_lookup());
			end
			if ($urandom_range(0, 199) == 0)
				drain();
		end
		drain();

		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("tb_slot_range_replica_router_core: done, clean");
		else
			$display("tb_slot_range_replica_router_core: done, errors");
		$finish;
	end
endmodule
